// ===== src/tvt_pkg.sv =====
// ---------------------------------------------------------------------------
// tvt_pkg: shared types and constants of the three-phase voltage trip core
// Word layouts of the reading and result channels, register map and resets.
// ---------------------------------------------------------------------------
`default_nettype none

package tvt_pkg;

   // widths of the fixed fields
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned IN_LEVELS = 3;

   // default number of watched phases
   localparam int unsigned PHASES_DEFAULT = 3;

   // register reset values
   localparam logic [LEVEL_W-1:0] HIGH_LIMIT_RESET = 8'd250;
   localparam logic [LEVEL_W-1:0] LOW_LIMIT_RESET = 8'd190;
   localparam logic [COUNT_W-1:0] PERSIST_TICKS_RESET = 8'd100;

   // saturation point of the persistence count
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      CSR_HIGH_LIMIT    = 2'd0,
      CSR_LOW_LIMIT     = 2'd1,
      CSR_PERSIST_TICKS = 2'd2
   } csr_index_type;

   // one tick of readings
   typedef struct packed {
      logic [LEVEL_W-1:0] level_a;
      logic [LEVEL_W-1:0] level_b;
      logic [LEVEL_W-1:0] level_c;
      logic               shutdown_first;
      logic               shutdown_second;
   } req_word_type;

   // state of the three output phases after one tick
   typedef struct packed {
      logic relay_a;
      logic relay_b;
      logic relay_c;
      logic lamp_a;
      logic lamp_b;
      logic lamp_c;
      logic frozen_a;
      logic frozen_b;
      logic frozen_c;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/three_phase_voltage_trip_core.sv =====
// ---------------------------------------------------------------------------
// three_phase_voltage_trip_core: over/under-voltage trip relay
// Per-phase window compare with persistence count, latched trip, shutdown.
// ---------------------------------------------------------------------------
// Pipeline: an accepted word waits in the input register, its result in the
// result register. Throughput: one word per cycle while the result channel is
// not stalled; the phase update is one compare-and-count step between them.
// Reset: synchronous; clears counts, trips and freezes, lamps go to 1,
// limits return to 250 / 190 and the persistence setting to 100.
`default_nettype none

module three_phase_voltage_trip_core #(
   parameter int unsigned PHASES = tvt_pkg::PHASES_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   // reading channel
   input  wire                  req_valid,
   output logic                 req_stall,
   input  tvt_pkg::req_word_type req_word,
   // result channel
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output tvt_pkg::rsp_word_type rsp_word,
   // register port
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [3:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int unsigned PAD_W = (PHASES > tvt_pkg::IN_LEVELS) ? PHASES : tvt_pkg::IN_LEVELS;

   // registers
   logic [tvt_pkg::LEVEL_W-1:0] high_limit_ff;
   logic [tvt_pkg::LEVEL_W-1:0] low_limit_ff;
   logic [tvt_pkg::COUNT_W-1:0] persist_ticks_ff;

   // input stage
   logic                  in_valid_ff;
   tvt_pkg::req_word_type in_word_ff;
   logic                  advance;

   // phase state
   logic [tvt_pkg::COUNT_W-1:0] count_ff [PHASES];
   logic [tvt_pkg::COUNT_W-1:0] count_in [PHASES];
   logic [PHASES-1:0] stop_ff, stop_in;
   logic [PHASES-1:0] relay_ff, relay_in;
   logic [PHASES-1:0] lamp_ff, lamp_in;

   // result stage
   logic                  rsp_valid_ff;
   tvt_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic [PAD_W-1:0]      relay_pad, lamp_pad, stop_pad;

   logic                  csr_write;
   tvt_pkg::csr_index_type csr_index;

   assign csr_index = tvt_pkg::csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff    <= tvt_pkg::HIGH_LIMIT_RESET;
         low_limit_ff     <= tvt_pkg::LOW_LIMIT_RESET;
         persist_ticks_ff <= tvt_pkg::PERSIST_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tvt_pkg::CSR_HIGH_LIMIT:    high_limit_ff    <= pwdata[7:0];
            tvt_pkg::CSR_LOW_LIMIT:     low_limit_ff     <= pwdata[7:0];
            tvt_pkg::CSR_PERSIST_TICKS: persist_ticks_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         tvt_pkg::CSR_HIGH_LIMIT:    prdata[7:0] = high_limit_ff;
         tvt_pkg::CSR_LOW_LIMIT:     prdata[7:0] = low_limit_ff;
         tvt_pkg::CSR_PERSIST_TICKS: prdata[7:0] = persist_ticks_ff;
         default: prdata = '0;
      endcase
   end

   // pipeline flow: input stage moves on when the result slot is free or leaving
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   // per-phase window check and persistence count
   always_comb begin
      logic [tvt_pkg::LEVEL_W-1:0] level;
      logic over, under;
      for (int p = 0; p < PHASES; p++) begin
         level = '0;
         if (p == 0) level = in_word_ff.level_a;
         if (p == 1) level = in_word_ff.level_b;
         if (p == 2) level = in_word_ff.level_c;
         over        = level > high_limit_ff;
         under       = level < low_limit_ff;
         count_in[p] = count_ff[p];
         stop_in[p]  = stop_ff[p];
         relay_in[p] = relay_ff[p];
         lamp_in[p]  = lamp_ff[p];
         if (!stop_ff[p]) begin
            if (over || under) begin
               if (count_ff[p] > persist_ticks_ff) begin
                  relay_in[p] = 1'b1;
                  lamp_in[p]  = !over;
                  stop_in[p]  = 1'b1;
               end else if (count_ff[p] != tvt_pkg::COUNT_MAX) begin
                  count_in[p] = count_ff[p] + 1'b1;
               end
            end else begin
               count_in[p] = '0;
            end
         end
      end
      // confirmed shutdown freezes every phase after the update
      if (in_word_ff.shutdown_first && in_word_ff.shutdown_second) begin
         stop_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff  <= '0;
         relay_ff <= '0;
         lamp_ff  <= '1;
         for (int p = 0; p < PHASES; p++) begin
            count_ff[p] <= '0;
         end
      end else if (advance) begin
         stop_ff  <= stop_in;
         relay_ff <= relay_in;
         lamp_ff  <= lamp_in;
         for (int p = 0; p < PHASES; p++) begin
            count_ff[p] <= count_in[p];
         end
      end
   end

   // result word, missing phases read as idle
   always_comb begin
      relay_pad = '0;
      lamp_pad  = '1;
      stop_pad  = '0;
      relay_pad[PHASES-1:0] = relay_in;
      lamp_pad[PHASES-1:0]  = lamp_in;
      stop_pad[PHASES-1:0]  = stop_in;
      rsp_word_in.relay_a  = relay_pad[0];
      rsp_word_in.relay_b  = relay_pad[1];
      rsp_word_in.relay_c  = relay_pad[2];
      rsp_word_in.lamp_a   = lamp_pad[0];
      rsp_word_in.lamp_b   = lamp_pad[1];
      rsp_word_in.lamp_c   = lamp_pad[2];
      rsp_word_in.frozen_a = stop_pad[0];
      rsp_word_in.frozen_b = stop_pad[1];
      rsp_word_in.frozen_c = stop_pad[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a frozen phase never comes back to watching
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(stop_ff) & ~stop_ff) == '0))
      else $error("frozen phase returned to watching");

   // a tripped relay always goes with a frozen phase
   a_relay_frozen: assert property (@(posedge clock) disable iff (reset)
      (relay_ff & ~stop_ff) == '0)
      else $error("relay on while phase still watched");

   // phase state only moves when a word passes into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(advance) |->
         $stable(stop_ff) && $stable(relay_ff) && $stable(lamp_ff))
      else $error("phase state changed without a word");

endmodule

`default_nettype wire

// ===== verif/tvt_trip_checker.sv =====
// ---------------------------------------------------------------------------
// tvt_trip_checker: result checker for the three-phase voltage trip core
// Watches the reading, result and register ports, keeps its own copy of the
// limits and of each phase's count and trip latches, predicts the status
// word for every accepted reading word and compares it field by field.
// ---------------------------------------------------------------------------

module tvt_trip_checker #(
   parameter int unsigned PHASES = tvt_pkg::PHASES_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   // reading channel
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  tvt_pkg::req_word_type req_word,
   // result channel
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  tvt_pkg::rsp_word_type rsp_word,
   // register port
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [3:0]            paddr,
   input  wire  [31:0]           pwdata,
   input  wire                   pready,
   // to the testbench top
   output int unsigned           mismatches,
   output int unsigned           in_flight
);

   // register copies
   logic [tvt_pkg::LEVEL_W-1:0] high_lim;
   logic [tvt_pkg::LEVEL_W-1:0] low_lim;
   logic [tvt_pkg::COUNT_W-1:0] persist_lim;

   // per-phase state
   logic [tvt_pkg::COUNT_W-1:0] dwell_count [PHASES];
   logic                        watch_off   [PHASES];
   logic                        relay_set   [PHASES];
   logic                        lamp_state  [PHASES];

   tvt_pkg::rsp_word_type predicted_status [$];
   int unsigned  errors_seen = 0;
   int unsigned  words_checked = 0;

   task automatic report_mismatch(string what);
      $display("status word %0d: %s", words_checked, what);
      errors_seen++;
   endtask

   // one tick of the window compare, persistence count and trip latches
   function automatic tvt_pkg::rsp_word_type advance_phases(tvt_pkg::req_word_type w);
      logic [tvt_pkg::LEVEL_W-1:0] lv;
      logic               over, under;
      logic [0:2]         r, l, f;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: lv = w.level_a;
            1: lv = w.level_b;
            2: lv = w.level_c;
            default: lv = '0;
         endcase
         over = lv > high_lim;
         under = lv < low_lim;
         if (!watch_off[p]) begin
            if (over || under) begin
               if (dwell_count[p] > persist_lim) begin
                  relay_set[p] = 1'b1;
                  lamp_state[p] = over ? 1'b0 : 1'b1;
                  watch_off[p] = 1'b1;
               end else if (dwell_count[p] != tvt_pkg::COUNT_MAX) begin
                  dwell_count[p] = dwell_count[p] + 1'b1;
               end
            end else begin
               dwell_count[p] = '0;
            end
         end
      end
      // both shutdown samples freeze everything, after the phase update
      if (w.shutdown_first && w.shutdown_second) begin
         for (int p = 0; p < PHASES; p++) watch_off[p] = 1'b1;
      end
      for (int p = 0; p < tvt_pkg::IN_LEVELS; p++) begin
         if (p < PHASES) begin
            r[p] = relay_set[p];
            l[p] = lamp_state[p];
            f[p] = watch_off[p];
         end else begin
            r[p] = 1'b0;
            l[p] = 1'b1;
            f[p] = 1'b0;
         end
      end
      return {r, l, f};
   endfunction

   // watch the three ports
   always @(posedge clock) begin : watch
      tvt_pkg::rsp_word_type want;
      logic [0:2]   got_relay, got_lamp, got_frozen;
      logic [0:2]   want_relay, want_lamp, want_frozen;
      if (reset) begin
         high_lim = tvt_pkg::HIGH_LIMIT_RESET;
         low_lim = tvt_pkg::LOW_LIMIT_RESET;
         persist_lim = tvt_pkg::PERSIST_TICKS_RESET;
         for (int p = 0; p < PHASES; p++) begin
            dwell_count[p] = '0;
            watch_off[p] = 1'b0;
            relay_set[p] = 1'b0;
            lamp_state[p] = 1'b1;
         end
         predicted_status.delete();
      end else begin
         // compare a result word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (predicted_status.size() == 0) begin
               report_mismatch("result word with no reading waiting");
            end else begin
               want = predicted_status.pop_front();
               got_relay = {rsp_word.relay_a, rsp_word.relay_b, rsp_word.relay_c};
               got_lamp = {rsp_word.lamp_a, rsp_word.lamp_b, rsp_word.lamp_c};
               got_frozen = {rsp_word.frozen_a, rsp_word.frozen_b, rsp_word.frozen_c};
               want_relay = {want.relay_a, want.relay_b, want.relay_c};
               want_lamp = {want.lamp_a, want.lamp_b, want.lamp_c};
               want_frozen = {want.frozen_a, want.frozen_b, want.frozen_c};
               for (int p = 0; p < tvt_pkg::IN_LEVELS; p++) begin
                  if (got_relay[p] !== want_relay[p])
                     report_mismatch($sformatf("relay_%c got %b, expected %b",
                        "a" + p, got_relay[p], want_relay[p]));
                  if (got_lamp[p] !== want_lamp[p])
                     report_mismatch($sformatf("lamp_%c got %b, expected %b",
                        "a" + p, got_lamp[p], want_lamp[p]));
                  if (got_frozen[p] !== want_frozen[p])
                     report_mismatch($sformatf("frozen_%c got %b, expected %b",
                        "a" + p, got_frozen[p], want_frozen[p]));
               end
            end
            words_checked++;
         end
         // predict the status word of an accepted reading word
         if (req_valid && !req_stall)
            predicted_status.push_back(advance_phases(req_word));
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (tvt_pkg::csr_index_type'(paddr[3:2]))
               tvt_pkg::CSR_HIGH_LIMIT:    high_lim = pwdata[tvt_pkg::LEVEL_W-1:0];
               tvt_pkg::CSR_LOW_LIMIT:     low_lim = pwdata[tvt_pkg::LEVEL_W-1:0];
               tvt_pkg::CSR_PERSIST_TICKS: persist_lim = pwdata[tvt_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      in_flight <= predicted_status.size();
      mismatches <= errors_seen;
   end

endmodule

// ===== verif/three_phase_voltage_trip_core_tb.sv =====
// ---------------------------------------------------------------------------
// three_phase_voltage_trip_core_tb: testbench top of the voltage trip core
// Drives reading words and register writes through several limit settings,
// stalls the result channel at random and leaves checking to the checker.
// ---------------------------------------------------------------------------

module three_phase_voltage_trip_core_tb;

   localparam int unsigned QUIET_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   tvt_pkg::req_word_type req_word = '0;
   logic         req_stall;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   tvt_pkg::rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int unsigned  mismatches;
   int unsigned  in_flight;
   int unsigned  quiet_cycles = 0;
   logic         calm = 1'b0;
   logic [7:0]   cur_high = tvt_pkg::HIGH_LIMIT_RESET;
   logic [7:0]   cur_low = tvt_pkg::LOW_LIMIT_RESET;

   always #1 clock = ~clock;

   three_phase_voltage_trip_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tvt_trip_checker trip_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   // random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 38);
   end

   // watchdog on cycles with no word or register access moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // reading inside or outside the current window
   function automatic logic [7:0] level_pick(logic want_in);
      if (cur_low > cur_high)
         return 8'($urandom_range(255));
      if (want_in)
         return 8'($urandom_range(cur_high, cur_low));
      if (cur_low > 0 && (cur_high == 8'd255 || $urandom_range(1) == 1))
         return 8'($urandom_range(cur_low - 1, 0));
      if (cur_high < 8'd255)
         return 8'($urandom_range(255, cur_high + 1));
      return 8'($urandom_range(255));
   endfunction

   // register write, only once every status word is back
   task automatic write_reg(tvt_pkg::csr_index_type idx, logic [7:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_limits(logic [7:0] high, logic [7:0] low, logic [7:0] persist);
      write_reg(tvt_pkg::CSR_HIGH_LIMIT, high);
      write_reg(tvt_pkg::CSR_LOW_LIMIT, low);
      write_reg(tvt_pkg::CSR_PERSIST_TICKS, persist);
      cur_high = high;
      cur_low = low;
   endtask

   // one reading word, with a random gap in front of it
   task automatic send_tick(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                            logic sd_first, logic sd_second);
      if (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_word <= '{level_a: a, level_b: b, level_c: c,
                    shutdown_first: sd_first, shutdown_second: sd_second};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // random word; percentages give the chance of an in-window reading
   task automatic rand_tick(int pct_a, int pct_b, int pct_c, logic allow_shutdown);
      logic s1, s2;
      s1 = 1'($urandom_range(1));
      s2 = 1'($urandom_range(1));
      if (!allow_shutdown && s1)
         s2 = 1'b0;
      send_tick(level_pick($urandom_range(99) < pct_a), level_pick($urandom_range(99) < pct_b),
                level_pick($urandom_range(99) < pct_c), s1, s2);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default window 190..250, persistence 100
      send_tick(8'd200, 8'd220, 8'd250, 1'b0, 1'b0);
      send_tick(8'd190, 8'd190, 8'd190, 1'b0, 1'b0);
      send_tick(8'd255, 8'd0, 8'd251, 1'b0, 1'b0);
      send_tick(8'd255, 8'd0, 8'd189, 1'b1, 1'b0);
      send_tick(8'haa, 8'h55, 8'd0, 1'b0, 1'b1);
      send_tick(8'h55, 8'haa, 8'd255, 1'b1, 1'b0);
      send_tick(8'd220, 8'd220, 8'd220, 1'b0, 1'b0);

      // widest window: nothing is out of range, zero persistence
      set_limits(8'd255, 8'd0, 8'd0);
      send_tick(8'd255, 8'd0, 8'd128, 1'b1, 1'b0);
      send_tick(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
      send_tick(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);

      // empty window: every reading counts, longest persistence
      set_limits(8'd0, 8'd255, 8'd254);
      send_tick(8'd0, 8'd255, 8'd1, 1'b0, 1'b0);
      send_tick(8'd255, 8'd0, 8'd128, 1'b1, 1'b0);
      repeat (4) rand_tick(0, 0, 0, 1'b0);

      // counts climb and clear, no phase gets near a trip
      for (int s = 0; s < 6; s++) begin
         set_limits(8'($urandom_range(255, 150)), 8'($urandom_range(120, 0)), 8'd254);
         calm <= (s == 3);
         repeat (50) rand_tick(50, 50, 50, 1'b0);
      end
      calm <= 1'b0;

      // phase c stays out of range until it trips at full persistence
      set_limits(8'd200, 8'd50, 8'd254);
      repeat (270) rand_tick(60, 60, 0, 1'b0);

      // short persistence, mostly in-window readings
      set_limits(8'($urandom_range(255, 150)), 8'($urandom_range(100, 0)), 8'd0);
      repeat (20) rand_tick(92, 92, 92, 1'b0);
      for (int s = 0; s < 3; s++) begin
         set_limits(8'($urandom_range(255, 150)), 8'($urandom_range(100, 0)),
                    8'($urandom_range(6, 1)));
         repeat (20) rand_tick(90, 90, 90, 1'b0);
      end

      // high limit below low limit: a reading between them is over-voltage
      set_limits(8'd60, 8'd200, 8'd2);
      repeat (12) rand_tick(0, 0, 0, 1'b0);

      // shutdown pairs allowed
      set_limits(8'd250, 8'd190, 8'd3);
      repeat (20) rand_tick(70, 70, 70, 1'b1);

      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== three_phase_voltage_trip_core.f =====
src/tvt_pkg.sv
src/three_phase_voltage_trip_core.sv
verif/tvt_trip_checker.sv
verif/three_phase_voltage_trip_core_tb.sv
